// ===== src/isingm_pkg.sv =====
// ----------------------------------------------------------------------------
// isingm_pkg
// Shared widths, codes and defaults for the Metropolis Ising site update block.
// ----------------------------------------------------------------------------
package isingm_pkg;

  // default lattice edge length (sites per row and per column)
  localparam int SIDE_DEFAULT = 32;

  // field widths of the stream payloads
  localparam int LS_W        = 10;  // load_site, visited_site
  localparam int RANDOM_BITS = 16;  // random_value
  localparam int THR_W       = 17;  // one acceptance threshold
  localparam int MAG_W       = 12;  // magnetization (signed)

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 24;

  // configuration register widths and indexes
  localparam int CFG_DATA_W  = 3 * THR_W;
  localparam int CFG_INDEX_W = 2;
  localparam int LOW_W       = 3 * THR_W;
  localparam int HIGH_W      = 2 * THR_W;

  localparam logic [CFG_INDEX_W-1:0] CFG_UP_LOW    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_UP_HIGH   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DOWN_LOW  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_DOWN_HIGH = 2'd3;

  // item kind carried on tuser
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  // four neighbours per site; a flip moves the spin sum by two
  localparam int NBRS      = 4;
  localparam int SPIN_STEP = 2;

endpackage

// ===== src/ising_metropolis_site_update.sv =====
// ----------------------------------------------------------------------------
// ising_metropolis_site_update
// Metropolis single-site update engine for a 2-D Ising lattice with periodic
// wrap. Spins live in a one-bit synchronous RAM; a sequencer reads the site
// and its four neighbours, applies the acceptance test and writes back.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            payload
//  --------  ---  -------------------  ------------------------------------------
//  s_*       in   s_tvalid / s_tready  tuser: func; tdata: load_site,
//                                      load_spin_up, random_value
//  m_*       out  m_tvalid / m_tready  tdata: visited_site, new_spin_up, flipped,
//                                      magnetization; tlast: sweep_end
//  cfg_*     in   cfg_we               cfg_index selects a threshold register
//
//  Update item: the accept cycle reads the centre site, the RD slots read the
//  four neighbours in turn, and the decide cycle decides and writes back. The
//  single RAM read port reads one lattice bit per cycle.
//  Load item: the site modulo (quotient, then remainder), one RAM read, one write.
//  After reset a clearing pass writes every site to spin up, with s_tready
//  low throughout. Configuration writes are taken at any time.
//  A finished result sits in the output register; the next item is taken while
//  it waits, and the decide cycle of that item holds until the register frees.
//
module ising_metropolis_site_update
  import isingm_pkg::*;
#(
  parameter int SIDE = SIDE_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [S_TDATA_W-1:0]   s_tdata,   // [9:0] load_site, [10] load_spin_up,
                                            // [26:11] random_value, [31:27] zero
  input  logic                   s_tuser,   // [0] func
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_TDATA_W-1:0]   m_tdata,   // [9:0] visited_site, [10] new_spin_up,
                                            // [11] flipped, [23:12] magnetization
  output logic                   m_tlast,   // sweep_end
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // --------------------------------------------------------------------------
  // Derived sizes
  // --------------------------------------------------------------------------
  localparam int SITES     = SIDE * SIDE;
  localparam int ROW_W     = $clog2(SIDE);
  localparam int ADDR_W    = $clog2(SITES);
  localparam int SITES_W   = $clog2(SITES + 1);
  localparam int TOT_W     = SITES_W + 1;
  localparam int WIDE_W    = (LS_W > SITES_W) ? LS_W : SITES_W;
  localparam int VS_W      = (ADDR_W > LS_W) ? ADDR_W : LS_W;
  localparam int EXT_W     = (TOT_W > MAG_W) ? TOT_W : MAG_W;
  // load_site mod SITES: quotient by reciprocal, then one correction
  localparam int MOD_SHIFT = 20;
  localparam int RECIP     = (1 << MOD_SHIFT) / SITES;
  localparam int PROD_W    = LS_W + MOD_SHIFT + 1;
  localparam int QS_W      = LS_W + SITES_W;

  // sequencer states
  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_LQ    = 3'd4;
  localparam logic [2:0] ST_LR    = 3'd5;
  localparam logic [2:0] ST_LRD   = 3'd6;
  localparam logic [2:0] ST_LEVAL = 3'd7;

  // neighbour read slots (centre is read in the accept cycle)
  localparam logic [2:0] SLOT_UP    = 3'd1;
  localparam logic [2:0] SLOT_DOWN  = 3'd2;
  localparam logic [2:0] SLOT_LEFT  = 3'd3;
  localparam logic [2:0] SLOT_RIGHT = 3'd4;

  localparam logic [ROW_W-1:0]  EDGE_LAST = ROW_W'(SIDE - 1);
  localparam logic [ADDR_W-1:0] SITE_LAST = ADDR_W'(SITES - 1);

  function automatic logic [ADDR_W-1:0] site_of(input logic [ROW_W-1:0] r,
                                                input logic [ROW_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(SIDE) + ADDR_W'(c);
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [2:0]              state;
  logic [2:0]              slot;
  logic [ADDR_W-1:0]       clr_addr;
  logic [ROW_W-1:0]        row, col;          // sweep pointer
  logic signed [TOT_W-1:0] total;             // running magnetization

  logic [LOW_W-1:0]        thresholds_up_low, thresholds_down_low;
  logic [HIGH_W-1:0]       thresholds_up_high, thresholds_down_high;

  logic [LS_W-1:0]         load_site;         // item payload, held for the item
  logic                    load_spin_up;
  logic [RANDOM_BITS-1:0]  random_value;
  logic [LS_W-1:0]         quot;
  logic [ADDR_W-1:0]       laddr;
  logic                    center_up;
  logic [2:0]              nup;               // up neighbours seen so far

  logic [LS_W-1:0]         out_site;
  logic                    out_up, out_flip;
  logic [MAG_W-1:0]        out_mag;

  // lattice RAM, one bit per site
  logic                    lattice [SITES];
  logic                    rd_bit;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  logic                    mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lattice[mem_waddr] <= mem_wdata;
    end
    rd_bit <= lattice[rd_addr];
  end

  // --------------------------------------------------------------------------
  // Neighbour addresses with periodic wrap
  // --------------------------------------------------------------------------
  logic [ROW_W-1:0]  row_m1, row_p1, col_m1, col_p1;
  logic [ADDR_W-1:0] center_addr;
  logic              sweep_last;

  assign row_m1      = (row == '0) ? EDGE_LAST : row - 1'b1;
  assign row_p1      = (row == EDGE_LAST) ? '0 : row + 1'b1;
  assign col_m1      = (col == '0) ? EDGE_LAST : col - 1'b1;
  assign col_p1      = (col == EDGE_LAST) ? '0 : col + 1'b1;
  assign center_addr = site_of(row, col);
  assign sweep_last  = (row == EDGE_LAST) && (col == EDGE_LAST);

  always_comb begin
    unique case (state) inside
      ST_RD: begin
        case (slot)
          SLOT_UP:   rd_addr = site_of(row_m1, col);
          SLOT_DOWN: rd_addr = site_of(row_p1, col);
          SLOT_LEFT: rd_addr = site_of(row, col_m1);
          default:   rd_addr = site_of(row, col_p1);
        endcase
      end
      ST_EVAL:          rd_addr = site_of(row, col_p1);  // keep last read stable
      ST_LRD, ST_LEVAL: rd_addr = laddr;
      default:          rd_addr = center_addr;
    endcase
  end

  // --------------------------------------------------------------------------
  // Load site modulo SITES
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0] recip_prod;
  logic [QS_W-1:0]   qs;
  logic [LS_W-1:0]   rem_raw;
  logic [WIDE_W-1:0] rem_w, rem_fix;

  assign recip_prod = PROD_W'(load_site) * PROD_W'(RECIP);
  assign qs         = QS_W'(quot) * QS_W'(SITES);
  assign rem_raw    = load_site - qs[LS_W-1:0];
  assign rem_w      = WIDE_W'(rem_raw);
  // quotient estimate is exact or one low
  assign rem_fix    = (rem_w >= WIDE_W'(SITES)) ? rem_w - WIDE_W'(SITES) : rem_w;

  // --------------------------------------------------------------------------
  // Acceptance test
  // --------------------------------------------------------------------------
  logic [2:0]        nup_all, cls;
  logic [LOW_W-1:0]  thr_low;
  logic [HIGH_W-1:0] thr_high;
  logic [THR_W-1:0]  thr;
  logic              flip, new_up;

  assign nup_all  = nup + 3'(rd_bit);
  // class = (spin * neighbour_sum + 4) / 2
  assign cls      = center_up ? nup_all : 3'(NBRS) - nup_all;
  assign thr_low  = center_up ? thresholds_up_low  : thresholds_down_low;
  assign thr_high = center_up ? thresholds_up_high : thresholds_down_high;

  always_comb begin
    case (cls)
      3'd0:    thr = thr_low[0 +: THR_W];
      3'd1:    thr = thr_low[THR_W +: THR_W];
      3'd2:    thr = thr_low[2*THR_W +: THR_W];
      3'd3:    thr = thr_high[0 +: THR_W];
      3'd4:    thr = thr_high[THR_W +: THR_W];
      default: thr = '0;
    endcase
  end

  assign flip   = THR_W'(random_value) < thr;
  assign new_up = center_up ^ flip;

  // --------------------------------------------------------------------------
  // Magnetization and write-back
  // --------------------------------------------------------------------------
  logic                    out_free;
  logic                    result_load;
  logic                    spin_changes, spin_goes_up;
  logic signed [TOT_W-1:0] total_next;
  logic signed [EXT_W-1:0] mag_ext;
  logic [VS_W-1:0]         site_ext;

  assign out_free    = !m_tvalid || m_tready;
  // a decide cycle hands its result to the output register
  assign result_load = out_free && ((state == ST_EVAL) || (state == ST_LEVAL));

  always_comb begin
    if (state == ST_LEVAL) begin
      spin_changes = (rd_bit != load_spin_up);
      spin_goes_up = load_spin_up;
    end else begin
      spin_changes = flip;
      spin_goes_up = new_up;
    end
    if (!spin_changes) begin
      total_next = total;
    end else if (spin_goes_up) begin
      total_next = total + TOT_W'(SPIN_STEP);
    end else begin
      total_next = total - TOT_W'(SPIN_STEP);
    end
  end

  assign mag_ext  = EXT_W'(total_next);
  assign site_ext = (state == ST_LEVAL) ? VS_W'(laddr) : VS_W'(center_addr);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = laddr;
    mem_wdata = load_spin_up;
    unique case (state)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = 1'b1;
      end
      ST_EVAL: begin
        mem_we    = out_free && flip;
        mem_waddr = center_addr;
        mem_wdata = new_up;
      end
      ST_LEVAL: begin
        mem_we    = out_free;
      end
      default: begin
        mem_we    = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= ST_CLR;
      slot                 <= SLOT_UP;
      clr_addr             <= '0;
      row                  <= '0;
      col                  <= '0;
      total                <= TOT_W'(SITES);
      m_tvalid             <= 1'b0;
      thresholds_up_low    <= '0;
      thresholds_up_high   <= '0;
      thresholds_down_low  <= '0;
      thresholds_down_high <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_UP_LOW:    thresholds_up_low    <= cfg_data[LOW_W-1:0];
          CFG_UP_HIGH:   thresholds_up_high   <= cfg_data[HIGH_W-1:0];
          CFG_DOWN_LOW:  thresholds_down_low  <= cfg_data[LOW_W-1:0];
          CFG_DOWN_HIGH: thresholds_down_high <= cfg_data[HIGH_W-1:0];
          default: ;
        endcase
      end

      if (result_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SITE_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            load_site    <= s_tdata[LS_W-1:0];
            load_spin_up <= s_tdata[LS_W];
            random_value <= s_tdata[LS_W+1 +: RANDOM_BITS];
            if (s_tuser == FUNC_UPDATE) begin
              state <= ST_RD;       // centre read issued this cycle
              slot  <= SLOT_UP;
            end else begin
              state <= ST_LQ;
            end
          end
        end
        ST_RD: begin
          // rd_bit holds the read issued one slot earlier
          if (slot == SLOT_UP) begin
            center_up <= rd_bit;
            nup       <= '0;
          end else begin
            nup <= nup + 3'(rd_bit);
          end
          if (slot == SLOT_RIGHT) begin
            state <= ST_EVAL;
          end else begin
            slot <= slot + 1'b1;
          end
        end
        ST_EVAL: begin
          if (out_free) begin
            out_site <= site_ext[LS_W-1:0];
            out_up   <= new_up;
            out_flip <= flip;
            out_mag  <= mag_ext[MAG_W-1:0];
            m_tlast  <= sweep_last;
            total    <= total_next;
            col      <= col_p1;
            if (col == EDGE_LAST) begin
              row <= row_p1;
            end
            state    <= ST_IDLE;
          end
        end
        ST_LQ: begin
          quot  <= recip_prod[MOD_SHIFT +: LS_W];
          state <= ST_LR;
        end
        ST_LR: begin
          laddr <= rem_fix[ADDR_W-1:0];
          state <= ST_LRD;
        end
        ST_LRD: begin
          state <= ST_LEVAL;
        end
        ST_LEVAL: begin
          if (out_free) begin
            out_site <= site_ext[LS_W-1:0];
            out_up   <= load_spin_up;
            out_flip <= 1'b0;
            out_mag  <= mag_ext[MAG_W-1:0];
            m_tlast  <= 1'b0;
            total    <= total_next;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {out_mag, out_flip, out_up, out_site};

endmodule

// ===== src/isingm_checker.sv =====
// ----------------------------------------------------------------------------
// isingm_checker
// Port-level checks for the Ising site update block, bound to the top level.
// ----------------------------------------------------------------------------
module isingm_checker
  import isingm_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [M_TDATA_W-1:0]   m_tdata,
  input logic                   m_tlast
);

  logic             seen;
  logic [MAG_W-1:0] prev_mag, cur_mag, mag_diff;
  logic             out_xfer;

  assign out_xfer = m_tvalid && m_tready;
  assign cur_mag  = m_tdata[LS_W+2 +: MAG_W];
  assign mag_diff = cur_mag - prev_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (out_xfer) begin
      seen     <= 1'b1;
      prev_mag <= cur_mag;
    end
  end

  // no result is pending right after reset
  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // one item in flight: ready drops after each input transfer
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in flight");

  // successive results move the magnetization by one spin at most,
  // and a flip always moves it
  a_mag_step: assert property (@(posedge clk) disable iff (rst)
    out_xfer && seen |->
      (mag_diff == MAG_W'(0) || mag_diff == MAG_W'(SPIN_STEP) ||
       mag_diff == MAG_W'(-SPIN_STEP)) &&
      (!m_tdata[LS_W+1] || mag_diff != MAG_W'(0)))
    else $error("magnetization step out of range");

  // a flip that raises the magnetization leaves the spin up
  a_flip_spin: assert property (@(posedge clk) disable iff (rst)
    out_xfer && m_tdata[LS_W+1] && seen && (mag_diff == MAG_W'(SPIN_STEP)) |->
      m_tdata[LS_W])
    else $error("flip up did not leave spin up");

endmodule

bind ising_metropolis_site_update isingm_checker u_isingm_checker (.*);

// ===== tb/sv/ising_metropolis_site_update_test.sv =====
// ----------------------------------------------------------------------------
// ising_metropolis_site_update_test
// Self-checking bench for the Metropolis site update block. A scoreboard keeps
// its own lattice, sweep pointer, magnetization and threshold copies. It
// predicts every result and checks the result stream field by field. Phases
// vary the thresholds and the idling on both streams. One phase also holds
// the result side off long enough to back up the input.
// ----------------------------------------------------------------------------
module ising_metropolis_site_update_test;
  timeunit 1ns;
  timeprecision 1ps;

  import isingm_pkg::*;

  localparam int SIDE          = SIDE_DEFAULT;
  localparam int SITES         = SIDE * SIDE;
  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 8;
  // idle cycles after the last result before a register write or the verdict;
  // this covers any work still in flight
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 300;
  // about 400 items plus heavy stalls and the hold-off, plus the clearing
  // pass after reset, taken many times over
  localparam int CYCLE_LIMIT   = 500_000;
  localparam int UPDATE_PCT    = 80;

  localparam logic [THR_W-1:0] THR_NEVER  = '0;
  localparam logic [THR_W-1:0] THR_ALMOST = 17'h0FFFF;  // fails only for the top draw
  localparam logic [THR_W-1:0] THR_ALWAYS = 17'h10000;  // 1.0 on the 2^16 scale
  localparam logic [THR_W-1:0] THR_FULL   = 17'h1FFFF;  // every threshold bit set

  // threshold settings applied to all ten classes at once
  typedef enum {SET_NEVER, SET_ALMOST, SET_ALWAYS, SET_FULL, SET_MIXED} thr_setting_t;

  typedef struct packed {
    logic [LS_W-1:0]  site;
    logic             spin_up;
    logic             flipped;
    logic [MAG_W-1:0] mag;
    logic             sweep_end;
  } site_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: lattice predictor plus the queue of expected site results
  // --------------------------------------------------------------------------
  class site_update_scoreboard;
    bit                spin_up [SITES];
    int unsigned       sweep_ptr;
    int                total_spin;
    logic [LOW_W-1:0]  up_low;
    logic [HIGH_W-1:0] up_high;
    logic [LOW_W-1:0]  down_low;
    logic [HIGH_W-1:0] down_high;
    site_result_t      expected_q [$];
    int                mismatches;

    function new();
      foreach (spin_up[k]) spin_up[k] = 1'b1;
      sweep_ptr  = 0;
      total_spin = SITES;
      up_low     = '0;
      up_high    = '0;
      down_low   = '0;
      down_high  = '0;
      mismatches = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        CFG_UP_LOW:    up_low    = value[LOW_W-1:0];
        CFG_UP_HIGH:   up_high   = value[HIGH_W-1:0];
        CFG_DOWN_LOW:  down_low  = value[LOW_W-1:0];
        CFG_DOWN_HIGH: down_high = value[HIGH_W-1:0];
        default: ;
      endcase
    endfunction

    // class 0..4 stands for spin*neighbour_sum of -4..+4
    function logic [THR_W-1:0] threshold(bit up, int cls);
      logic [LOW_W-1:0]  lo;
      logic [HIGH_W-1:0] hi;
      lo = up ? up_low : down_low;
      hi = up ? up_high : down_high;
      if (cls < 3) return lo[THR_W*cls +: THR_W];
      return hi[THR_W*(cls-3) +: THR_W];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // one accepted input transfer: advance the lattice, queue the result
    function void take_item(logic func, logic [LS_W-1:0] load_site, logic load_up,
                            logic [RANDOM_BITS-1:0] rnd);
      site_result_t want;
      int unsigned  site;
      int unsigned  row;
      int unsigned  col;
      int unsigned  nup;
      int           nsum;
      int           prod;
      bit           up;
      want = '0;
      if (func == FUNC_LOAD) begin
        site = load_site % SITES;
        if (spin_up[site] != load_up) total_spin += load_up ? SPIN_STEP : -SPIN_STEP;
        spin_up[site] = load_up;
        up = load_up;
      end else begin
        site = sweep_ptr % SITES;
        row  = site / SIDE;
        col  = site % SIDE;
        // periodic wrap on both axes
        nup  = int'(spin_up[((row + SIDE - 1) % SIDE) * SIDE + col])
             + int'(spin_up[((row + 1) % SIDE) * SIDE + col])
             + int'(spin_up[row * SIDE + (col + SIDE - 1) % SIDE])
             + int'(spin_up[row * SIDE + (col + 1) % SIDE]);
        nsum = SPIN_STEP * int'(nup) - NBRS;
        up   = spin_up[site];
        prod = up ? nsum : -nsum;
        if (rnd < threshold(up, (prod + NBRS) / SPIN_STEP)) begin
          want.flipped  = 1'b1;
          up            = !up;
          spin_up[site] = up;
          total_spin   += up ? SPIN_STEP : -SPIN_STEP;
        end
        want.sweep_end = (site == SITES - 1);
        sweep_ptr      = want.sweep_end ? 0 : site + 1;
      end
      want.site    = site[LS_W-1:0];
      want.spin_up = up;
      want.mag     = total_spin[MAG_W-1:0];
      expected_q.push_back(want);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
    endtask

    task check_result(logic [M_TDATA_W-1:0] data, logic last);
      site_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing pending", data, '0);
        return;
      end
      want = expected_q.pop_front();
      if (data[LS_W-1:0] !== want.site)
        report_mismatch("visited_site", data[LS_W-1:0], want.site);
      if (data[LS_W] !== want.spin_up)
        report_mismatch("new_spin_up", data[LS_W], want.spin_up);
      if (data[LS_W+1] !== want.flipped)
        report_mismatch("flipped", data[LS_W+1], want.flipped);
      if (data[LS_W+2 +: MAG_W] !== want.mag)
        report_mismatch("magnetization", data[LS_W+2 +: MAG_W], want.mag);
      if (last !== want.sweep_end)
        report_mismatch("sweep_end", last, want.sweep_end);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals; every block input starts at a known value
  // --------------------------------------------------------------------------
  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata   = '0;   // [9:0] load_site, [10] load_spin_up,
                                            // [26:11] random_value, [31:27] zero
  logic                   s_tuser   = 1'b0; // [0] func
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;          // [9:0] visited_site, [10] new_spin_up,
                                            // [11] flipped, [23:12] magnetization
  logic                   m_tlast;          // sweep_end
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int          tx_idle_pct  = 0;     // read only by the stimulus process
  int          rx_stall_pct = 0;     // written by NBA, read by the sink at the edge
  logic        rx_hold      = 1'b0;  // long sink hold-off, owned by hold_off()
  int unsigned cycle_count  = 0;

  site_update_scoreboard ising_board = new();

  ising_metropolis_site_update #(
    .SIDE(SIDE)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result sink: checks a transfer on the edge that completes it, then picks
  // the next tready; pre-edge values only, so no race with the block's NBAs
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) ising_board.check_result(m_tdata, m_tlast);
      m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // offer one item; optional idle cycles first, returns on the accepting edge.
  // tvalid stays high into the next item unless that item idles first.
  task automatic send_item(logic func, logic [LS_W-1:0] site, logic up,
                           logic [RANDOM_BITS-1:0] rnd);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {{(S_TDATA_W-RANDOM_BITS-1-LS_W){1'b0}}, rnd, up, site};
    do @(posedge clk); while (!s_tready);
    ising_board.take_item(func, site, up, rnd);
  endtask

  // drop tvalid, drain every pending result, then let the pipeline go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (ising_board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    ising_board.set_register(index, value);
  endtask

  function automatic logic [THR_W-1:0] pick_threshold(thr_setting_t setting);
    case (setting)
      SET_NEVER:  return THR_NEVER;
      SET_ALMOST: return THR_ALMOST;
      SET_ALWAYS: return THR_ALWAYS;
      SET_FULL:   return THR_FULL;
      default: begin
        // mixed: edge values and ordinary acceptance probabilities per class
        case ($urandom_range(5))
          0:       return THR_NEVER;
          1:       return THR_ALMOST;
          2:       return THR_ALWAYS;
          3:       return THR_FULL;
          default: return THR_W'($urandom_range(THR_ALWAYS));
        endcase
      end
    endcase
  endfunction

  // block must be idle; writes all four threshold registers
  task automatic configure(thr_setting_t setting);
    write_cfg(CFG_UP_LOW, {pick_threshold(setting), pick_threshold(setting),
                           pick_threshold(setting)});
    write_cfg(CFG_UP_HIGH, CFG_DATA_W'({pick_threshold(setting), pick_threshold(setting)}));
    write_cfg(CFG_DOWN_LOW, {pick_threshold(setting), pick_threshold(setting),
                             pick_threshold(setting)});
    write_cfg(CFG_DOWN_HIGH, CFG_DATA_W'({pick_threshold(setting), pick_threshold(setting)}));
    cfg_we <= 1'b0;
  endtask

  // runs in its own process; tready stays low for the whole count
  task automatic hold_off(int cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold <= 1'b0;
  endtask

  function automatic logic [RANDOM_BITS-1:0] draw();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return RANDOM_BITS'($urandom_range(2**RANDOM_BITS - 1));
    endcase
  endfunction

  // mostly updates so the sweep keeps moving; loads reshape the lattice so
  // every neighbour-sum class shows up for both spin values
  task automatic run_phase(int count, int tx_pct, int rx_pct, thr_setting_t setting,
                           bit squeeze);
    settle();
    configure(setting);
    tx_idle_pct   = tx_pct;
    rx_stall_pct <= rx_pct;
    for (int n = 0; n < count; n++) begin
      if (squeeze && n == count / 4) begin
        fork
          hold_off(HOLD_CYCLES);
        join_none
      end
      if ($urandom_range(99) < UPDATE_PCT)
        send_item(FUNC_UPDATE, LS_W'($urandom_range(SITES - 1)), 1'($urandom_range(1)),
                  draw());
      else
        send_item(FUNC_LOAD, LS_W'($urandom_range(SITES - 1)), 1'($urandom_range(1)),
                  draw());
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // thresholds still at reset: zero never accepts, even for a zero draw
    send_item(FUNC_UPDATE, '0, 1'b0, '0);
    // loads: changing spin moves the sum, same spin leaves it alone
    send_item(FUNC_LOAD, 10'd1023, 1'b0, 16'hAAAA);
    send_item(FUNC_LOAD, 10'd0,    1'b0, 16'h5555);
    send_item(FUNC_LOAD, 10'd0,    1'b0, '1);
    send_item(FUNC_LOAD, 10'd1,    1'b1, '0);
    // surround site 1 (next in the sweep) with down spins across the top wrap
    send_item(FUNC_LOAD, 10'd33,  1'b0, '0);
    send_item(FUNC_LOAD, 10'd2,   1'b0, '0);
    send_item(FUNC_LOAD, 10'd993, 1'b0, '0);
    settle();

    // widest threshold field: the top draw still flips
    configure(SET_FULL);
    send_item(FUNC_UPDATE, 10'h2AA, 1'b1, '1);
    settle();

    // exactly 1.0: every draw accepted
    configure(SET_ALWAYS);
    send_item(FUNC_UPDATE, 10'h155, 1'b0, '1);
    send_item(FUNC_UPDATE, '1, 1'b1, 16'h8000);
    settle();

    // one below 1.0: only the top draw is refused
    configure(SET_ALMOST);
    send_item(FUNC_UPDATE, '0, 1'b0, '1);
    send_item(FUNC_UPDATE, '0, 1'b0, 16'hFFFE);
    send_item(FUNC_LOAD, 10'h2AA, 1'b1, 16'h5555);
    send_item(FUNC_LOAD, 10'h155, 1'b0, 16'hAAAA);

    // random part; the sweep crosses the left and right edges of the lattice
    run_phase(60,  0,  0, SET_MIXED,  1'b0);  // no idling either side
    run_phase(60, 74,  0, SET_FULL,   1'b0);  // sender idles
    run_phase(60,  0, 74, SET_NEVER,  1'b0);  // receiver stalls
    run_phase(80, 38, 38, SET_MIXED,  1'b0);  // both
    run_phase(70,  0,  0, SET_ALWAYS, 1'b1);  // long hold-off backs up input
    run_phase(55, 38, 38, SET_MIXED,  1'b0);
    settle();

    if (ising_board.mismatches == 0 && ising_board.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
